// File: src/ljpevr_pkg.sv
// ----------------------------------------------------------------------------
// ljpevr_pkg
// Shared types, widths and constants of the Lennard-Jones pair energy,
// virial and pair-distance histogram unit.
// ----------------------------------------------------------------------------
package ljpevr_pkg;

  localparam int MAX_PARTICLES_DEF = 1024;
  localparam int NUM_BINS_DEF      = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BOX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IBW    = 2'd2;

  localparam logic [22:0] BOX_RST    = 23'd1048576;
  localparam logic [31:0] CUTOFF_RST = 32'd16777216;
  localparam logic [23:0] IBW_RST    = 24'd1048576;

  localparam int R_W    = 52;
  localparam int ROOT_W = 26;
  localparam int U_W    = 62;
  localparam int Q_W    = 64;

  localparam logic [U_W-1:0] INV_CAP = 62'h2000_0000_0000_0000;
  localparam logic [19:0]    COUNT_MAX = 20'hFFFFF;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic               last_particle;
  } item_t;

  typedef struct packed {
    logic [5:0]         bin_index;
    logic [19:0]        bin_count;
    logic signed [47:0] potential_energy;
    logic signed [47:0] virial;
    logic               last_bin;
  } result_t;

endpackage

// File: src/ljpevr_mul.sv
// ----------------------------------------------------------------------------
// ljpevr_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module ljpevr_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

// File: src/ljpevr_sqrt.sv
// ----------------------------------------------------------------------------
// ljpevr_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module ljpevr_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ljpevr_pkg::R_W-1:0]     radicand,
  output logic                           done,
  output logic [ljpevr_pkg::ROOT_W-1:0]  root
);

  localparam int RW = ljpevr_pkg::R_W;
  localparam int TW = ljpevr_pkg::ROOT_W;

  logic          run;
  logic [4:0]    cnt;
  logic [RW-1:0] rad;
  logic [TW:0]   rem;
  logic [TW+2:0] sh;
  logic [TW+2:0] trial;
  logic          take;

  assign sh    = {rem, rad[RW-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign take  = sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (run) begin
        rad <= rad << 2;
        if (take) begin
          rem  <= (TW+1)'(sh - trial);
          root <= {root[TW-2:0], 1'b1};
        end else begin
          rem  <= (TW+1)'(sh);
          root <= {root[TW-2:0], 1'b0};
        end
        if (cnt == 5'(TW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 5'd1;
      end
    end
  end

endmodule

// File: src/ljpevr_div.sv
// ----------------------------------------------------------------------------
// ljpevr_div
// Iterative restoring divider: quotient of 2^64 by the squared distance,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ljpevr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ljpevr_pkg::R_W-1:0]  divisor,
  output logic                        done,
  output logic [ljpevr_pkg::Q_W-1:0]  quotient
);

  localparam int RW = ljpevr_pkg::R_W;
  localparam int QW = ljpevr_pkg::Q_W;

  logic          run;
  logic [6:0]    cnt;
  logic [RW-1:0] dvs;
  logic [RW-1:0] rem;
  logic [RW:0]   sh;
  logic          take;

  assign sh   = {rem, cnt == 7'd0};
  assign take = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run      <= 1'b1;
        cnt      <= '0;
        dvs      <= divisor;
        rem      <= '0;
        quotient <= '0;
      end else if (run) begin
        rem      <= take ? RW'(sh - {1'b0, dvs}) : RW'(sh);
        quotient <= {quotient[QW-2:0], take};
        if (cnt == 7'(QW)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 7'd1;
      end
    end
  end

endmodule

// File: src/lj_pair_energy_virial_rdf_unit.sv
// ----------------------------------------------------------------------------
// lj_pair_energy_virial_rdf_unit
// Lennard-Jones energy, virial and pair-distance histogram of one frame.
// ----------------------------------------------------------------------------
// Usage: load one particle per transaction with start while busy is low.
// Positions go into three position memories; a particle beyond
// MAX_PARTICLES is dropped. The transaction with last_particle set
// starts the frame: busy stays high while a sequencer walks all pairs
// i<j through one shared multiplier, an iterative square root and an
// iterative divider. Then NUM_BINS results come out, each marked by
// result_valid for one cycle, with last_bin on the final bin; busy then
// drops. The receiver cannot stall. Reset clears the particle count, sums
// and histogram valid bits and restores the register defaults. Registers
// are written through cfg_we / cfg_index / cfg_data; the user must write
// them only while busy is low, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module lj_pair_energy_virial_rdf_unit #(
  parameter int MAX_PARTICLES = ljpevr_pkg::MAX_PARTICLES_DEF,
  parameter int NUM_BINS      = ljpevr_pkg::NUM_BINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  ljpevr_pkg::item_t                   item,
  output logic                                result_valid,
  output ljpevr_pkg::result_t                 result,
  input  logic                                cfg_we,
  input  logic [ljpevr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ljpevr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int BW = $clog2(NUM_BINS);
  localparam int RW = ljpevr_pkg::R_W;
  localparam int TW = ljpevr_pkg::ROOT_W;
  localparam int UW = ljpevr_pkg::U_W;
  localparam int QW = ljpevr_pkg::Q_W;

  localparam logic [1:0] MQ_U4  = 2'd0;
  localparam logic [1:0] MQ_U6  = 2'd1;
  localparam logic [1:0] MQ_U12 = 2'd2;

  localparam logic signed [63:0] SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN = -64'sh0000_8000_0000_0000;

  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_RDI   = 18'h00002,
    ST_LATI  = 18'h00004,
    ST_RDJ   = 18'h00008,
    ST_DIFF  = 18'h00010,
    ST_SQ    = 18'h00020,
    ST_SQST  = 18'h00040,
    ST_SQRT  = 18'h00080,
    ST_BIN0  = 18'h00100,
    ST_BIN   = 18'h00200,
    ST_HUPD  = 18'h00400,
    ST_DIVST = 18'h00800,
    ST_DIV   = 18'h01000,
    ST_MQ    = 18'h02000,
    ST_ACC   = 18'h04000,
    ST_NEXT  = 18'h08000,
    ST_OUTR  = 18'h10000,
    ST_OUTE  = 18'h20000
  } state_t;

  function automatic logic [24:0] min_abs(logic signed [23:0] a, logic signed [23:0] b,
                                          logic [22:0] bx);
    logic signed [25:0] d;
    logic signed [26:0] d2;
    logic signed [26:0] b2;
    logic signed [25:0] bs;
    logic signed [25:0] m;
    d  = 26'(a) - 26'(b);
    d2 = 27'(d) <<< 1;
    b2 = $signed({4'b0, bx});
    bs = $signed({3'b0, bx});
    if (d2 > b2) m = d - bs;
    else if (d2 < -b2) m = d + bs;
    else m = d;
    return m[25] ? 25'(-m) : 25'(m);
  endfunction

  function automatic logic signed [47:0] sat48(logic signed [47:0] s, logic signed [63:0] t);
    logic signed [63:0] sum;
    sum = 64'(s) + t;
    if (sum > SUM_MAX) return SUM_MAX[47:0];
    if (sum < SUM_MIN) return SUM_MIN[47:0];
    return sum[47:0];
  endfunction

  state_t state;

  logic [22:0] box;
  logic [31:0] cutoff;
  logic [23:0] ibw;

  logic signed [23:0] mem_x [MAX_PARTICLES];
  logic signed [23:0] mem_y [MAX_PARTICLES];
  logic signed [23:0] mem_z [MAX_PARTICLES];
  logic signed [23:0] rdx, rdy, rdz;
  logic [AW-1:0]      rd_addr;

  logic [19:0]   hist [NUM_BINS];
  logic [19:0]   hrd;
  logic [BW-1:0] haddr;
  logic [NUM_BINS-1:0] hvld;
  logic          hist_we;
  logic [19:0]   hval;
  logic [20:0]   hinc;

  logic [CW-1:0] loaded;
  logic [CW-1:0] loaded_next;
  logic          accept;
  logic [AW-1:0] pi, pj;
  logic signed [23:0] xi, yi, zi;
  logic [24:0]   dxa, dya, dza;
  logic [2:0]    cnt;
  logic [1:0]    msel;
  logic [RW-1:0] rsq;
  logic [TW-1:0] root;
  logic          in_cut;
  logic [BW-1:0] hbin;
  logic          hin;
  logic [UW-1:0] u2, u4, u6, u12;
  logic [63:0]   acc;
  logic signed [47:0] esum, vsum;
  logic [BW-1:0] k;

  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_p;
  logic [UW-1:0] opa, opb;
  logic [63:0]   mq_sum;
  logic [UW-1:0] mq_res;
  logic signed [63:0] ediff, vdiff;

  logic          sq_done;
  logic [TW-1:0] sq_root;
  logic          dv_done;
  logic [QW-1:0] dv_q;

  logic [CW:0]   j_inc;
  logic [CW:0]   i_inc2;

  ljpevr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  ljpevr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_SQST),
    .radicand (rsq),
    .done     (sq_done),
    .root     (sq_root)
  );

  ljpevr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DIVST),
    .divisor  (rsq),
    .done     (dv_done),
    .quotient (dv_q)
  );

  assign busy    = state != ST_IDLE;
  assign accept  = start && !busy;
  assign rd_addr = (state == ST_RDI) ? pi : pj;
  assign loaded_next = (loaded < CW'(MAX_PARTICLES)) ? loaded + CW'(1) : loaded;
  assign j_inc   = (CW+1)'(pj) + (CW+1)'(1);
  assign i_inc2  = (CW+1)'(pi) + (CW+1)'(2);

  assign hval    = hvld[hbin] ? hrd : 20'd0;
  assign hinc    = 21'(hval) + 21'd2;
  assign hist_we = (state == ST_HUPD) && hin;

  always_comb begin
    case (state)
      ST_BIN:  haddr = mul_p[32 +: BW];
      ST_OUTR: haddr = k;
      default: haddr = hbin;
    endcase
  end

  always_comb begin
    case (msel)
      MQ_U6:   opa = u4;
      MQ_U12:  opa = u6;
      default: opa = u2;
    endcase
    opb = (msel == MQ_U12) ? u6 : u2;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ: begin
        case (cnt)
          3'd0:    mul_a = 32'(dxa);
          3'd1:    mul_a = 32'(dya);
          3'd2:    mul_a = 32'(dza);
          default: mul_a = '0;
        endcase
        mul_b = mul_a;
      end
      ST_BIN0: begin
        mul_a = 32'(root);
        mul_b = 32'(ibw);
      end
      ST_MQ: begin
        case (cnt)
          3'd0: begin
            mul_a = opa[31:0];
            mul_b = opb[31:0];
          end
          3'd1: begin
            mul_a = opa[31:0];
            mul_b = 32'(opb[UW-1:32]);
          end
          3'd2: begin
            mul_a = 32'(opa[UW-1:32]);
            mul_b = opb[31:0];
          end
          3'd3: begin
            mul_a = 32'(opa[UW-1:32]);
            mul_b = 32'(opb[UW-1:32]);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mq_sum = acc + {mul_p[31:0], 32'h0};
  assign mq_res = (mul_p >= 64'h2000_0000 || mq_sum > 64'(ljpevr_pkg::INV_CAP)) ?
                  ljpevr_pkg::INV_CAP : mq_sum[UW-1:0];

  assign ediff = $signed({2'b0, u12}) - $signed({2'b0, u6});
  assign vdiff = $signed({1'b0, u12, 1'b0}) - $signed({2'b0, u6});

  always_ff @(posedge clk) begin
    if (accept && loaded < CW'(MAX_PARTICLES)) begin
      mem_x[loaded[AW-1:0]] <= item.pos_x;
      mem_y[loaded[AW-1:0]] <= item.pos_y;
      mem_z[loaded[AW-1:0]] <= item.pos_z;
    end
    rdx <= mem_x[rd_addr];
    rdy <= mem_y[rd_addr];
    rdz <= mem_z[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist[hbin] <= (hinc > 21'(ljpevr_pkg::COUNT_MAX)) ? ljpevr_pkg::COUNT_MAX : hinc[19:0];
    end
    hrd <= hist[haddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box    <= ljpevr_pkg::BOX_RST;
      cutoff <= ljpevr_pkg::CUTOFF_RST;
      ibw    <= ljpevr_pkg::IBW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ljpevr_pkg::REG_BOX:    box    <= cfg_data[22:0];
        ljpevr_pkg::REG_CUTOFF: cutoff <= cfg_data[31:0];
        ljpevr_pkg::REG_IBW:    ibw    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      loaded       <= '0;
      hvld         <= '0;
      esum         <= '0;
      vsum         <= '0;
      result_valid <= 1'b0;
      cnt          <= '0;
      msel         <= MQ_U4;
      k            <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            loaded <= loaded_next;
            if (item.last_particle) begin
              hvld <= '0;
              esum <= '0;
              vsum <= '0;
              k    <= '0;
              pi   <= '0;
              pj   <= AW'(1);
              state <= (loaded_next >= CW'(2)) ? ST_RDI : ST_OUTR;
            end
          end
        end
        ST_RDI:  state <= ST_LATI;
        ST_LATI: begin
          xi    <= rdx;
          yi    <= rdy;
          zi    <= rdz;
          state <= ST_RDJ;
        end
        ST_RDJ:  state <= ST_DIFF;
        ST_DIFF: begin
          dxa   <= min_abs(xi, rdx, box);
          dya   <= min_abs(yi, rdy, box);
          dza   <= min_abs(zi, rdz, box);
          cnt   <= '0;
          state <= ST_SQ;
        end
        ST_SQ: begin
          case (cnt)
            3'd1:    rsq <= mul_p[RW-1:0];
            3'd2:    rsq <= rsq + mul_p[RW-1:0];
            3'd3:    rsq <= rsq + mul_p[RW-1:0];
            default: ;
          endcase
          cnt <= cnt + 3'd1;
          if (cnt == 3'd3) state <= ST_SQST;
        end
        ST_SQST: state <= ST_SQRT;
        ST_SQRT: begin
          if (sq_done) begin
            root  <= sq_root;
            state <= ST_BIN0;
          end
        end
        ST_BIN0: state <= ST_BIN;
        ST_BIN: begin
          hbin   <= mul_p[32 +: BW];
          hin    <= mul_p[63:32] < 32'(NUM_BINS);
          in_cut <= rsq < RW'({cutoff, 16'h0});
          state  <= ST_HUPD;
        end
        ST_HUPD: begin
          if (hin) hvld[hbin] <= 1'b1;
          cnt  <= '0;
          msel <= MQ_U4;
          if (!in_cut) begin
            state <= ST_NEXT;
          end else if (rsq <= RW'(8)) begin
            u2    <= ljpevr_pkg::INV_CAP;
            state <= ST_MQ;
          end else begin
            state <= ST_DIVST;
          end
        end
        ST_DIVST: state <= ST_DIV;
        ST_DIV: begin
          if (dv_done) begin
            u2    <= (dv_q > QW'(ljpevr_pkg::INV_CAP)) ? ljpevr_pkg::INV_CAP : dv_q[UW-1:0];
            state <= ST_MQ;
          end
        end
        ST_MQ: begin
          case (cnt)
            3'd1:    acc <= {32'h0, mul_p[63:32]};
            3'd2:    acc <= acc + mul_p;
            3'd3:    acc <= acc + mul_p;
            default: ;
          endcase
          if (cnt == 3'd4) begin
            cnt <= '0;
            case (msel)
              MQ_U4:   u4  <= mq_res;
              MQ_U6:   u6  <= mq_res;
              default: u12 <= mq_res;
            endcase
            if (msel == MQ_U12) state <= ST_ACC;
            else msel <= msel + 2'd1;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_ACC: begin
          esum  <= sat48(esum, ediff >>> 14);
          vsum  <= sat48(vsum, vdiff >>> 13);
          state <= ST_NEXT;
        end
        ST_NEXT: begin
          if (j_inc < (CW+1)'(loaded)) begin
            pj    <= pj + AW'(1);
            state <= ST_RDJ;
          end else if (i_inc2 < (CW+1)'(loaded)) begin
            pi    <= pi + AW'(1);
            pj    <= AW'(i_inc2);
            state <= ST_RDI;
          end else begin
            state <= ST_OUTR;
          end
        end
        ST_OUTR: state <= ST_OUTE;
        ST_OUTE: begin
          result_valid            <= 1'b1;
          result.bin_index        <= 6'(k);
          result.bin_count        <= hvld[k] ? hrd : 20'd0;
          result.potential_energy <= esum;
          result.virial           <= vsum;
          result.last_bin         <= k == BW'(NUM_BINS - 1);
          if (k == BW'(NUM_BINS - 1)) begin
            loaded <= '0;
            state  <= ST_IDLE;
          end else begin
            k     <= k + BW'(1);
            state <= ST_OUTR;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: verif/lj_pair_energy_virial_rdf_unit_test.sv
// ----------------------------------------------------------------------------
// lj_pair_energy_virial_rdf_unit_test
//
// Self-checking testbench for the Lennard-Jones energy, virial and
// pair-distance histogram unit.
//
// Particles are loaded frame by frame. The testbench keeps its own model of
// the loaded positions and computes the histogram and the saturated sums for
// each frame. It then checks every bin result the block emits against that
// prediction.
//
// Stimulus runs in three parts:
//   - a directed table under the reset register values;
//   - phases with extreme register settings;
//   - phases with random settings, built mostly from small well-formed frames
//     with some full-range noise positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lj_pair_energy_virial_rdf_unit_test;

  localparam int NBINS = 64;
  localparam logic [ljpevr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint unsigned CAP = 64'h2000_0000_0000_0000;
  localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -64'sh8000_0000_0000;
  localparam int WATCHDOG_LIMIT = 400000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  ljpevr_pkg::item_t item;
  logic result_valid;
  ljpevr_pkg::result_t result;
  logic cfg_we;
  logic [ljpevr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ljpevr_pkg::CFG_DATA_W-1:0] cfg_data;

  lj_pair_energy_virial_rdf_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model state
  logic [22:0] box_q;
  logic [31:0] cutoff_q;
  logic [23:0] ibw_q;
  int pos_x_mem[$];
  int pos_y_mem[$];
  int pos_z_mem[$];
  ljpevr_pkg::result_t expected_bins[$];
  ljpevr_pkg::result_t frame_bins[NBINS];

  int errors = 0;
  int frames = 0;
  int bins_seen = 0;
  int quiet_cycles = 0;
  bit allow_idle = 1;

  typedef struct {
    ljpevr_pkg::item_t it;
    bit                all_zero;
  } stim_row_t;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mul_q32(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    p = p >> 32;
    return (p > CAP) ? CAP : p[63:0];
  endfunction

  function automatic longint fold_box(longint d);
    longint b;
    b = longint'(box_q);
    if (2 * d > b) return d - b;
    if (2 * d < -b) return d + b;
    return d;
  endfunction

  function automatic longint sat48(longint s);
    if (s > SUM_HI) return SUM_HI;
    if (s < SUM_LO) return SUM_LO;
    return s;
  endfunction

  // Fill frame_bins with the histogram and sums of the loaded particles.
  task automatic compute_frame();
    longint dx, dy, dz, e_sum, v_sum;
    longint unsigned rsq, root, bin, u2, u4, u6, u12;
    int cnt[NBINS];
    for (int k = 0; k < NBINS; k++) cnt[k] = 0;
    e_sum = 0;
    v_sum = 0;
    for (int i = 0; i + 1 < pos_x_mem.size(); i++) begin
      for (int j = i + 1; j < pos_x_mem.size(); j++) begin
        dx = fold_box(longint'(pos_x_mem[i]) - pos_x_mem[j]);
        dy = fold_box(longint'(pos_y_mem[i]) - pos_y_mem[j]);
        dz = fold_box(longint'(pos_z_mem[i]) - pos_z_mem[j]);
        rsq = dx * dx + dy * dy + dz * dz;
        root = isqrt(rsq);
        bin = (root * longint'(ibw_q)) >> 32;
        if (bin < NBINS) cnt[bin] = (cnt[bin] + 2 > 20'hFFFFF) ? 20'hFFFFF : cnt[bin] + 2;
        if (rsq < (longint'(cutoff_q) << 16)) begin
          if (rsq <= 1) u2 = CAP;
          else begin
            u2 = (64'd0 - rsq) / rsq + 1;
            if (u2 > CAP) u2 = CAP;
          end
          u4 = mul_q32(u2, u2);
          u6 = mul_q32(u4, u2);
          u12 = mul_q32(u6, u6);
          e_sum = sat48(e_sum + ((longint'(u12) - longint'(u6)) >>> 14));
          v_sum = sat48(v_sum + ((2 * longint'(u12) - longint'(u6)) >>> 13));
        end
      end
    end
    for (int k = 0; k < NBINS; k++) begin
      frame_bins[k].bin_index = 6'(k);
      frame_bins[k].bin_count = 20'(cnt[k]);
      frame_bins[k].potential_energy = e_sum[47:0];
      frame_bins[k].virial = v_sum[47:0];
      frame_bins[k].last_bin = (k == NBINS - 1);
    end
  endtask

  // Update the model with one accepted particle; queue bins on frame end.
  task automatic load_particle(ljpevr_pkg::item_t it, bit all_zero);
    if (pos_x_mem.size() < ljpevr_pkg::MAX_PARTICLES_DEF) begin
      pos_x_mem.push_back(it.pos_x);
      pos_y_mem.push_back(it.pos_y);
      pos_z_mem.push_back(it.pos_z);
    end
    if (it.last_particle) begin
      compute_frame();
      for (int k = 0; k < NBINS; k++) begin
        if (all_zero) expected_bins.push_back('{k[5:0], 20'd0, 48'sd0, 48'sd0, k == NBINS - 1});
        else expected_bins.push_back(frame_bins[k]);
      end
      pos_x_mem.delete();
      pos_y_mem.delete();
      pos_z_mem.delete();
      frames++;
    end
  endtask

  task automatic send_particle(ljpevr_pkg::item_t it, bit all_zero = 0);
    if (allow_idle && $urandom_range(0, 99) < 8) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    item <= it;
    do @(posedge clk); while (busy);
    load_particle(it, all_zero);
  endtask

  task automatic drain();
    start <= 0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(logic [22:0] b, logic [31:0] c, logic [23:0] w);
    cfg_we <= 1;
    cfg_index <= ljpevr_pkg::REG_BOX;    cfg_data <= 32'(b); @(posedge clk);
    cfg_index <= ljpevr_pkg::REG_CUTOFF; cfg_data <= c;      @(posedge clk);
    cfg_index <= ljpevr_pkg::REG_IBW;    cfg_data <= 32'(w); @(posedge clk);
    cfg_index <= REG_UNUSED; cfg_data <= $urandom; @(posedge clk);
    cfg_we <= 0;
    box_q = b;
    cutoff_q = c;
    ibw_q = w;
  endtask

  function automatic ljpevr_pkg::item_t make_particle(bit noise, bit last);
    ljpevr_pkg::item_t it;
    int half;
    half = int'(box_q) / 2;
    if (noise) begin
      it.pos_x = 24'($urandom);
      it.pos_y = 24'($urandom);
      it.pos_z = 24'($urandom);
    end else begin
      it.pos_x = 24'(int'($urandom_range(0, 2 * half)) - half);
      it.pos_y = 24'(int'($urandom_range(0, 2 * half)) - half);
      it.pos_z = 24'(int'($urandom_range(0, 2 * half)) - half);
    end
    it.last_particle = last;
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      bins_seen++;
      if (expected_bins.size() == 0) begin
        $error("unexpected result transaction bin_index=%0d", result.bin_index);
        errors++;
      end else begin
        ljpevr_pkg::result_t e;
        e = expected_bins.pop_front();
        if (result.bin_index !== e.bin_index) begin
          $error("bin_index exp %0d got %0d", e.bin_index, result.bin_index);
          errors++;
        end
        if (result.bin_count !== e.bin_count) begin
          $error("bin_count exp %0d got %0d", e.bin_count, result.bin_count);
          errors++;
        end
        if (result.potential_energy !== e.potential_energy) begin
          $error("potential_energy exp %0d got %0d", e.potential_energy,
                 result.potential_energy);
          errors++;
        end
        if (result.virial !== e.virial) begin
          $error("virial exp %0d got %0d", e.virial, result.virial);
          errors++;
        end
        if (result.last_bin !== e.last_bin) begin
          $error("last_bin exp %0d got %0d", e.last_bin, result.last_bin);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || result_valid || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    stim_row_t table_rows[$];
    int n_items;
    int fsize;
    bit noisy;
    rst = 1;
    start = 0;
    item = '0;
    cfg_we = 0;
    cfg_index = ljpevr_pkg::REG_BOX;
    cfg_data = '0;
    box_q = ljpevr_pkg::BOX_RST;
    cutoff_q = ljpevr_pkg::CUTOFF_RST;
    ibw_q = ljpevr_pkg::IBW_RST;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // lone particle, coincident pair, opposite extremes, unit distance,
    // pair beyond the last bin, small frame with negative coordinates
    table_rows = '{
      '{'{24'sd100, -24'sd5, 24'sd7, 1'b1}, 1'b1},
      '{'{24'sd0, 24'sd0, 24'sd0, 1'b0}, 1'b0},
      '{'{24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b0},
      '{'{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0}, 1'b0},
      '{'{-24'sh800000, -24'sh800000, -24'sh800000, 1'b1}, 1'b0},
      '{'{24'sd0, 24'sd0, 24'sd0, 1'b0}, 1'b0},
      '{'{24'sd65536, 24'sd0, 24'sd0, 1'b1}, 1'b0},
      '{'{24'sd0, 24'sd0, 24'sd0, 1'b0}, 1'b0},
      '{'{24'sd300000, 24'sd300000, 24'sd300000, 1'b1}, 1'b0},
      '{'{-24'sd70000, 24'sd12345, -24'sd400000, 1'b0}, 1'b0},
      '{'{24'sd80000, -24'sd90000, 24'sd500000, 1'b0}, 1'b0},
      '{'{-24'sd1, 24'sd1, 24'sd0, 1'b1}, 1'b0}
    };
    foreach (table_rows[r]) send_particle(table_rows[r].it, table_rows[r].all_zero);
    n_items = table_rows.size();

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: write_regs(23'd0, 32'hFFFFFFFF, 24'hFFFFFF);
        1: write_regs(23'h7FFFFF, 32'd0, 24'd0);
        2: write_regs(23'd1, 32'd65536, 24'd65536);
        default: write_regs(23'($urandom_range(65536, 8 * 65536)),
                            ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 26),
                            24'($urandom_range(1 << 16, 32 << 16)));
      endcase
      allow_idle = (phase != 4);
      for (int f = 0; f < 12; f++) begin
        fsize = (f == 5 && phase == 6) ? 24 : $urandom_range(2, 6);
        noisy = ($urandom_range(0, 4) == 0);
        for (int p = 0; p < fsize; p++) begin
          send_particle(make_particle(noisy || $urandom_range(0, 9) == 0, p == fsize - 1));
          n_items++;
        end
      end
    end

    drain();
    $display("%0d particle transactions in %0d frames, %0d bin results checked",
             n_items, frames, bins_seen);
    $display("register settings covered zero, maximum and random values");
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
